>>> src/i2cbm_pkg.sv
// Shared types and constants for the bit-level I2C master.
package i2cbm_pkg;

  localparam int unsigned TICK_COUNTER_WIDTH_DEF = 16;
  localparam int unsigned PHASE_TICKS_W = 16;
  localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RST = 16'd10;
  localparam int unsigned PHASE_IDX_W = 5;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_ACK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ACT_SDA    = 2'd0,
    ACT_SCL    = 2'd1,
    ACT_SAMPLE = 2'd2
  } act_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       rejected;
  } out_word_t;

  localparam logic [PHASE_IDX_W-1:0] LAST_START = 5'd3;
  localparam logic [PHASE_IDX_W-1:0] LAST_STOP  = 5'd2;
  localparam logic [PHASE_IDX_W-1:0] LAST_WRITE = 5'd27;
  localparam logic [PHASE_IDX_W-1:0] LAST_READ  = 5'd24;
  localparam logic [PHASE_IDX_W-1:0] LAST_ACK   = 5'd2;

  function automatic logic [PHASE_IDX_W-1:0] last_phase(input op_t op);
    logic [PHASE_IDX_W-1:0] r;
    unique case (op)
      OP_START: r = LAST_START;
      OP_STOP:  r = LAST_STOP;
      OP_WRITE: r = LAST_WRITE;
      OP_READ:  r = LAST_READ;
      default:  r = LAST_ACK;
    endcase
    return r;
  endfunction

endpackage

>>> src/i2c_bit_level_master_unit.sv
// Bit-level I2C master: runs start/stop/write/read/ack phase lists one tick per word.
// The result word for an input tick is registered at its accepting edge.
// Throughput: one tick word per cycle while the input is not stalled; the phase logic sits
//   between the state registers and the result register with no iteration.
// Input is stalled only while a result word waits and the output is stalled.
// Reset (rst_n low, synchronous): idle, both lines released, phase length 10 ticks.
module i2c_bit_level_master_unit
  #(parameter int unsigned TICK_COUNTER_WIDTH = i2cbm_pkg::TICK_COUNTER_WIDTH_DEF)
  (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  i2cbm_pkg::in_word_t    in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output i2cbm_pkg::out_word_t   out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
  );
  import i2cbm_pkg::*;

  localparam int unsigned TW = TICK_COUNTER_WIDTH;
  localparam int unsigned CMPW = (TW + 1 > PHASE_TICKS_W) ? TW + 1 : PHASE_TICKS_W;

  logic [PHASE_TICKS_W-1:0] ph_ticks_r;
  logic [TW-1:0]            cnt_r, cnt_nxt;
  logic [PHASE_IDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]               sub_r, sub_nxt;
  logic [2:0]               bit_r, bit_nxt;
  op_t                      op_r, op_nxt;
  logic                     busy_r, busy_nxt;
  logic [7:0]               so_r, so_nxt;
  logic [7:0]               si_r, si_nxt;
  logic                     ack_r, ack_nxt;
  logic                     scl_r, scl_nxt;
  logic                     sda_r, sda_nxt;
  logic                     out_valid_r;
  out_word_t                out_data_r, out_data_nxt;

  logic                     acc;
  logic                     start;
  logic                     rej;
  logic                     done;
  logic                     phase_end;
  logic [TW:0]              sum;
  logic [PHASE_TICKS_W-1:0] pt_eff;
  logic [PHASE_IDX_W-1:0]   idx_cur;
  logic [1:0]               sub_cur;
  logic [2:0]               bit_cur;
  logic [TW-1:0]            cnt_cur;
  act_t                     act;
  logic                     act_val;

  assign in_stall  = out_valid_r & out_stall;
  assign acc       = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign start = in_data.cmd_valid & ~busy_r & (in_data.opcode <= OP_ACK);
  assign rej   = in_data.cmd_valid & busy_r;

  assign idx_cur = start ? '0 : idx_r;
  assign sub_cur = start ? '0 : sub_r;
  assign bit_cur = start ? '0 : bit_r;
  assign cnt_cur = start ? '0 : cnt_r;
  assign op_nxt  = start ? op_t'(in_data.opcode) : op_r;
  assign pt_eff  = (ph_ticks_r == '0) ? PHASE_TICKS_W'(1) : ph_ticks_r;
  assign sum     = {1'b0, cnt_cur} + (TW + 1)'(1);
  assign phase_end = (CMPW'(sum) >= CMPW'(pt_eff)) || sum[TW];

  always_comb begin
    act     = ACT_SCL;
    act_val = 1'b0;
    unique case (op_nxt)
      OP_START: begin
        act     = (idx_cur == 5'd0 || idx_cur == 5'd2) ? ACT_SDA : ACT_SCL;
        act_val = (idx_cur < 5'd2);
      end
      OP_STOP: begin
        act     = (idx_cur == 5'd1) ? ACT_SCL : ACT_SDA;
        act_val = (idx_cur != 5'd0);
      end
      OP_WRITE: begin
        if (idx_cur < 5'd24) begin
          act     = (sub_cur == 2'd0) ? ACT_SDA : ACT_SCL;
          act_val = (sub_cur == 2'd0) ? so_nxt[3'd7 - bit_cur] : (sub_cur == 2'd1);
        end else if (idx_cur == 5'd24) begin
          act     = ACT_SDA;
          act_val = 1'b1;
        end else if (idx_cur == 5'd25) begin
          act     = ACT_SCL;
          act_val = 1'b1;
        end else if (idx_cur == 5'd26) begin
          act     = ACT_SAMPLE;
        end else begin
          act     = ACT_SCL;
        end
      end
      OP_READ: begin
        if (idx_cur == 5'd0) begin
          act     = ACT_SDA;
          act_val = 1'b1;
        end else begin
          act     = (sub_cur == 2'd1) ? ACT_SAMPLE : ACT_SCL;
          act_val = (sub_cur == 2'd0);
        end
      end
      default: begin
        act     = (idx_cur == 5'd0) ? ACT_SDA : ACT_SCL;
        act_val = (idx_cur == 5'd0) ? so_nxt[0] : (idx_cur == 5'd1);
      end
    endcase
  end

  always_comb begin
    so_nxt   = so_r;
    si_nxt   = si_r;
    if (start) begin
      so_nxt = (in_data.opcode == OP_ACK) ? {7'd0, in_data.ack_to_send} : in_data.tx_byte;
      if (in_data.opcode == OP_READ) begin
        si_nxt = '0;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r | start;
    idx_nxt  = idx_cur;
    sub_nxt  = sub_cur;
    bit_nxt  = bit_cur;
    cnt_nxt  = cnt_cur;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    ack_nxt  = ack_r;
    done     = 1'b0;
    if (busy_r | start) begin
      if (cnt_cur == '0) begin
        case (act)
          ACT_SDA: sda_nxt = act_val;
          ACT_SCL: scl_nxt = act_val;
          default: begin
            if (op_nxt == OP_WRITE) begin
              ack_nxt = in_data.sda_in;
            end
          end
        endcase
      end
      if (phase_end) begin
        cnt_nxt = '0;
        if (idx_cur >= last_phase(op_nxt)) begin
          busy_nxt = 1'b0;
          idx_nxt  = '0;
          done     = 1'b1;
        end else begin
          idx_nxt = idx_cur + 5'd1;
          if (op_nxt == OP_READ && idx_cur == 5'd0) begin
            sub_nxt = '0;
          end else if (sub_cur == 2'd2) begin
            sub_nxt = '0;
            bit_nxt = bit_cur + 3'd1;
          end else begin
            sub_nxt = sub_cur + 2'd1;
          end
        end
      end else begin
        cnt_nxt = sum[TW-1:0];
      end
    end
  end

  logic [7:0] si_fin;
  assign si_fin = ((busy_r | start) && cnt_cur == '0 && act == ACT_SAMPLE && op_nxt != OP_WRITE)
                  ? {si_nxt[6:0], in_data.sda_in} : si_nxt;

  always_comb begin
    out_data_nxt.scl_level    = scl_nxt;
    out_data_nxt.sda_level    = sda_nxt;
    out_data_nxt.busy_res     = busy_r | start;
    out_data_nxt.done_res     = done;
    out_data_nxt.rx_byte      = si_fin;
    out_data_nxt.ack_received = ack_nxt;
    out_data_nxt.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_ticks_r  <= PHASE_TICKS_RST;
      cnt_r       <= '0;
      idx_r       <= '0;
      sub_r       <= '0;
      bit_r       <= '0;
      op_r        <= OP_START;
      busy_r      <= 1'b0;
      so_r        <= '0;
      si_r        <= '0;
      ack_r       <= 1'b1;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ph_ticks_r <= cfg_data;
      end
      if (acc) begin
        cnt_r  <= cnt_nxt;
        idx_r  <= idx_nxt;
        sub_r  <= sub_nxt;
        bit_r  <= bit_nxt;
        op_r   <= op_nxt;
        busy_r <= busy_nxt;
        so_r   <= so_nxt;
        si_r   <= si_fin;
        ack_r  <= ack_nxt;
        scl_r  <= scl_nxt;
        sda_r  <= sda_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // a command landing on a running sequence is flagged in the result word for its own tick
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    acc && busy_r && in_data.cmd_valid |=> out_data_r.rejected)
    else $error("busy command not flagged");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> out_data_r.busy_res && !busy_r)
    else $error("done without finishing sequence");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (idx_r == '0) && (cnt_r == '0))
    else $error("phase state left over while idle");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_phase(op_r))
    else $error("phase index past last phase");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(busy_r) && $stable(idx_r) && $stable(cnt_r))
    else $error("state moved without a tick");

endmodule
